// ----- rtl/hnes_pkg.sv -----
// Shared types and constants for the hex nearest-element search.
package hnes_pkg;

  localparam int DIST_W      = 12;
  localparam int OUT_COORD_W = 11;

  typedef logic [DIST_W-1:0]             dist_t;
  typedef logic signed [OUT_COORD_W-1:0] out_coord_t;

  localparam dist_t      CUTOFF_RESET = dist_t'(999);
  localparam out_coord_t NO_COORD     = out_coord_t'(-1);

endpackage

// ----- rtl/hnes_if.sv -----
// Valid/ready channel interfaces for query items and search results.
interface hnes_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] query_row;
  logic [COORD_BITS-1:0] query_col;
  logic [COORD_BITS-1:0] elem_row;
  logic [COORD_BITS-1:0] elem_col;
  logic                  elem_valid;
  logic                  first_item;
  logic                  last_item;

  modport source (
    output valid, query_row, query_col, elem_row, elem_col, elem_valid, first_item, last_item,
    input  ready
  );
  modport sink (
    input  valid, query_row, query_col, elem_row, elem_col, elem_valid, first_item, last_item,
    output ready
  );
endinterface

interface hnes_out_if;
  import hnes_pkg::*;

  logic       valid;
  logic       ready;
  out_coord_t closest_row;
  out_coord_t closest_col;
  logic       found;
  dist_t      best_distance;

  modport source (
    output valid, closest_row, closest_col, found, best_distance,
    input  ready
  );
  modport sink (
    input  valid, closest_row, closest_col, found, best_distance,
    output ready
  );
endinterface

// ----- rtl/hex_nearest_element_search.sv -----
// Top level of the hex nearest-element search: input stage, running best and result register.
//
//   channel   dir   handshake       payload
//   in_chan   in    valid/ready     query_row, query_col, elem_row, elem_col, elem_valid,
//                                   first_item, last_item
//   out_chan  out   valid/ready     closest_row, closest_col, found, best_distance
//   cfg       in    cfg_we          cfg_wdata (distance cutoff)
//
// One transaction is taken per cycle unless a stalled result holds the input stage; an
// item is registered there, its distance and running-best update are computed as it moves
// on, and a last item's result is registered. The running-best update is the feedback loop.
// Reset is synchronous on rst_n low and sets the cutoff to 999 with an empty best.
// A stalled result holds the input stage only when that stage carries another last item.
module hex_nearest_element_search #(
  parameter int COORD_BITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  hnes_pkg::dist_t   cfg_wdata,
  hnes_in_if.sink           in_chan,
  hnes_out_if.source        out_chan
);
  import hnes_pkg::*;

  localparam int DW    = COORD_BITS + 2;
  localparam int CMP_W = (DW > DIST_W) ? DW : DIST_W;

  dist_t cutoff_r;

  logic                  a_valid_r, a_valid_nxt;
  logic [COORD_BITS-1:0] a_qr_r, a_qc_r, a_er_r, a_ec_r;
  logic                  a_elem_r, a_first_r, a_last_r;

  dist_t      best_dist_r, best_dist_nxt;
  out_coord_t best_row_r, best_row_nxt;
  out_coord_t best_col_r, best_col_nxt;
  logic       have_best_r, have_best_nxt;

  logic       out_valid_r, out_valid_nxt;
  out_coord_t out_row_r, out_col_r;
  logic       out_found_r;
  dist_t      out_dist_r;

  logic          in_fire, a_fire;
  logic [DW-1:0] elem_dist;

  assign a_fire        = a_valid_r && (!a_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !a_valid_r || a_fire;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      cutoff_r  <= CUTOFF_RESET;
    end else begin
      a_valid_r <= a_valid_nxt;
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_qr_r    <= in_chan.query_row;
      a_qc_r    <= in_chan.query_col;
      a_er_r    <= in_chan.elem_row;
      a_ec_r    <= in_chan.elem_col;
      a_elem_r  <= in_chan.elem_valid;
      a_first_r <= in_chan.first_item;
      a_last_r  <= in_chan.last_item;
    end
  end

  hnes_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .q_row    (a_qr_r),
    .q_col    (a_qc_r),
    .e_row    (a_er_r),
    .e_col    (a_ec_r),
    .hex_dist (elem_dist)
  );

  // A first item restarts from the cutoff; only a strictly smaller distance wins.
  always_comb begin
    dist_t      base_dist;
    out_coord_t base_row, base_col;
    logic       base_have;
    logic       take;
    base_dist = a_first_r ? cutoff_r : best_dist_r;
    base_row  = a_first_r ? NO_COORD : best_row_r;
    base_col  = a_first_r ? NO_COORD : best_col_r;
    base_have = a_first_r ? 1'b0 : have_best_r;
    take      = a_elem_r && (CMP_W'(elem_dist) < CMP_W'(base_dist));
    best_dist_nxt = take ? DIST_W'(elem_dist) : base_dist;
    best_row_nxt  = take ? out_coord_t'(a_er_r) : base_row;
    best_col_nxt  = take ? out_coord_t'(a_ec_r) : base_col;
    have_best_nxt = take ? 1'b1 : base_have;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_fire && a_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= CUTOFF_RESET;
      best_row_r  <= NO_COORD;
      best_col_r  <= NO_COORD;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (a_fire) begin
        best_dist_r <= best_dist_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
        have_best_r <= have_best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_last_r) begin
      out_row_r   <= best_row_nxt;
      out_col_r   <= best_col_nxt;
      out_found_r <= have_best_nxt;
      out_dist_r  <= best_dist_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.closest_row   = out_row_r;
  assign out_chan.closest_col   = out_col_r;
  assign out_chan.found         = out_found_r;
  assign out_chan.best_distance = out_dist_r;

`ifndef SYNTHESIS
  a_empty_best: assert property (@(posedge clk) disable iff (!rst_n)
    !have_best_r |-> (best_row_r == NO_COORD) && (best_col_r == NO_COORD))
    else $error("empty running best carries a position");

  a_none_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_row_r == NO_COORD) && (out_col_r == NO_COORD))
    else $error("result without a winner carries a position");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fire && a_last_r) |=> out_valid_r)
    else $error("last item did not produce a result");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !(a_fire && a_last_r))
    else $error("pending result overwritten");
`endif
endmodule

// ----- rtl/hnes_dist.sv -----
// Hex distance between two odd-column offset positions via cube coordinates.
module hnes_dist #(
  parameter int COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0] q_row,
  input  logic [COORD_BITS-1:0] q_col,
  input  logic [COORD_BITS-1:0] e_row,
  input  logic [COORD_BITS-1:0] e_col,
  output logic [COORD_BITS+1:0] hex_dist
);
  // Cube differences stay below 1.5 * 2^COORD_BITS in magnitude.
  localparam int W = COORD_BITS + 3;

  logic signed [W-1:0] r0, r1, c0, c1, h0, h1;
  logic signed [W-1:0] dxs, dys, dzs;
  logic [W-1:0]        ax, ay, az, m;

  assign r0 = signed'(W'(q_row));
  assign r1 = signed'(W'(e_row));
  assign c0 = signed'(W'(q_col));
  assign c1 = signed'(W'(e_col));
  assign h0 = signed'(W'(q_col >> 1));
  assign h1 = signed'(W'(e_col >> 1));

  // z = -x - y, so |dz| is the magnitude of dx + dy.
  assign dxs = c1 - c0;
  assign dys = (r1 - r0) - (h1 - h0);
  assign dzs = dxs + dys;

  assign ax = dxs[W-1] ? unsigned'(-dxs) : unsigned'(dxs);
  assign ay = dys[W-1] ? unsigned'(-dys) : unsigned'(dys);
  assign az = dzs[W-1] ? unsigned'(-dzs) : unsigned'(dzs);

  always_comb begin
    m = ax;
    if (ay > m) begin
      m = ay;
    end
    if (az > m) begin
      m = az;
    end
  end

  assign hex_dist = m[W-2:0];
endmodule

// ----- tb/tb_hex_nearest_element_search.sv -----
// Self-checking testbench for the hex nearest-element search block.
`timescale 1ns / 100ps

module tb_hex_nearest_element_search;
  import hnes_pkg::*;

  localparam int COORD_BITS = 10;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
  localparam int IDLE_PCT   = 17;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 1000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t query_row;
    coord_t query_col;
    coord_t elem_row;
    coord_t elem_col;
    logic   elem_valid;
    logic   first_item;
    logic   last_item;
  } search_item_t;

  typedef struct {
    out_coord_t closest_row;
    out_coord_t closest_col;
    logic       found;
    dist_t      best_distance;
  } search_result_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  dist_t cfg_wdata;

  hnes_in_if #(.COORD_BITS(COORD_BITS)) in_chan ();
  hnes_out_if out_chan ();

  hex_nearest_element_search #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  search_item_t   pending_items[$];
  search_result_t expected_results[$];
  search_item_t   item_on_bus;
  search_result_t want;

  // Predictor copy of the cutoff register and the running best.
  dist_t      cutoff_reg;
  dist_t      run_dist;
  out_coord_t run_row;
  out_coord_t run_col;
  logic       run_found;

  int items_queued;
  int items_accepted;
  int error_count;
  bit no_idle;
  int rx_hold_req;
  int rx_hold_seen;
  int hold_left;

  always #2 clk = ~clk;

  function automatic int hex_distance(coord_t qr, coord_t qc, coord_t er, coord_t ec);
    int qy;
    int ey;
    int dx;
    int dy;
    int dz;
    int m;
    // Odd-column offset to cube: y = row - floor(col / 2), z = -x - y.
    qy = int'(qr) - int'(qc >> 1);
    ey = int'(er) - int'(ec >> 1);
    dx = int'(ec) - int'(qc);
    dy = ey - qy;
    dz = -dx - dy;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    m = dx;
    if (dy > m) m = dy;
    if (dz > m) m = dz;
    return m;
  endfunction

  task automatic update_running_best(input search_item_t it);
    int d;
    if (it.first_item) begin
      run_dist  = cutoff_reg;
      run_row   = NO_COORD;
      run_col   = NO_COORD;
      run_found = 1'b0;
    end
    if (it.elem_valid) begin
      d = hex_distance(it.query_row, it.query_col, it.elem_row, it.elem_col);
      if (d < int'(run_dist)) begin
        run_dist  = dist_t'(d);
        run_row   = out_coord_t'({1'b0, it.elem_row});
        run_col   = out_coord_t'({1'b0, it.elem_col});
        run_found = 1'b1;
      end
    end
    if (it.last_item) begin
      expected_results.push_back('{run_row, run_col, run_found, run_dist});
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    error_count++;
    if (error_count <= 60) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp_val);
    end
  endtask

  task automatic add_item(input int qr, input int qc, input int er, input int ec,
                          input bit v, input bit f, input bit l);
    search_item_t it;
    it.query_row  = coord_t'(qr);
    it.query_col  = coord_t'(qc);
    it.elem_row   = coord_t'(er);
    it.elem_col   = coord_t'(ec);
    it.elem_valid = v;
    it.first_item = f;
    it.last_item  = l;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic int near_coord(input coord_t base, input int radius);
    int v;
    v = int'(base) + int'($urandom_range(2 * radius)) - radius;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // One search of n items; a few get broken framing or a moved query.
  task automatic add_search(input int n);
    int  qr;
    int  qc;
    int  er;
    int  ec;
    int  radius;
    bit  f;
    bit  l;
    qr = $urandom_range(COORD_MAX);
    qc = $urandom_range(COORD_MAX);
    radius = ($urandom_range(1) != 0) ? 3 : 40;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        qr = $urandom_range(COORD_MAX);
        qc = $urandom_range(COORD_MAX);
      end
      if ($urandom_range(9) < 6) begin
        er = near_coord(coord_t'(qr), radius);
        ec = near_coord(coord_t'(qc), radius);
      end else begin
        er = $urandom_range(COORD_MAX);
        ec = $urandom_range(COORD_MAX);
      end
      f = (k == 0);
      l = (k == n - 1);
      if ($urandom_range(19) == 0) begin
        f = $urandom_range(1);
        l = $urandom_range(1);
      end
      add_item(qr, qc, er, ec, $urandom_range(9) != 0, f, l);
    end
  endtask

  task automatic write_cutoff(input dist_t value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cutoff_reg = value;
  endtask

  // Returns once every queued item is taken and every result has come back, then
  // lets items still in the pipeline that produce no result drain.
  task automatic wait_drained;
    while (items_accepted != items_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Input driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        update_running_best(item_on_bus);
        items_accepted++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          item_on_bus = pending_items.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.query_row  <= item_on_bus.query_row;
          in_chan.query_col  <= item_on_bus.query_col;
          in_chan.elem_row   <= item_on_bus.elem_row;
          in_chan.elem_col   <= item_on_bus.elem_col;
          in_chan.elem_valid <= item_on_bus.elem_valid;
          in_chan.first_item <= item_on_bus.first_item;
          in_chan.last_item  <= item_on_bus.last_item;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, closest_row",
                          out_chan.closest_row, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_chan.closest_row !== want.closest_row)
            report_mismatch("closest_row", out_chan.closest_row, want.closest_row);
          if (out_chan.closest_col !== want.closest_col)
            report_mismatch("closest_col", out_chan.closest_col, want.closest_col);
          if (out_chan.found !== want.found)
            report_mismatch("found", out_chan.found, want.found);
          if (out_chan.best_distance !== want.best_distance)
            report_mismatch("best_distance", out_chan.best_distance, want.best_distance);
        end
      end
      if (rx_hold_req != rx_hold_seen) begin
        rx_hold_seen = rx_hold_req;
        hold_left    = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase_start;
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_chan.valid      = 1'b0;
    in_chan.query_row  = '0;
    in_chan.query_col  = '0;
    in_chan.elem_row   = '0;
    in_chan.elem_col   = '0;
    in_chan.elem_valid = 1'b0;
    in_chan.first_item = 1'b0;
    in_chan.last_item  = 1'b0;
    out_chan.ready     = 1'b0;
    items_queued       = 0;
    items_accepted     = 0;
    error_count        = 0;
    no_idle            = 1'b0;
    rx_hold_req        = 0;
    rx_hold_seen       = 0;
    hold_left          = 0;
    cutoff_reg         = CUTOFF_RESET;
    run_dist           = CUTOFF_RESET;
    run_row            = NO_COORD;
    run_col            = NO_COORD;
    run_found          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed searches under the reset cutoff.
    add_item(0, 0, 0, 0, 0, 1, 1);                 // empty set
    add_item(5, 6, 5, 6, 1, 1, 1);                 // exact hit
    add_item(0, 0, COORD_MAX, COORD_MAX, 1, 1, 0); // corner to corner
    add_item(0, 0, COORD_MAX, 0, 1, 0, 0);
    add_item(0, 0, 0, COORD_MAX, 1, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 1);
    add_item(COORD_MAX, COORD_MAX, 0, 0, 1, 1, 0); // query moves within the search
    add_item(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, 1, 0, 0);
    add_item(512, 511, 512, 512, 1, 0, 1);
    add_item(10, 10, 9, 10, 1, 1, 0);              // equal distances keep the earlier one
    add_item(10, 10, 11, 10, 1, 0, 1);
    add_item(10, 10, 10, 10, 1, 0, 1);             // no first item: search carries on
    add_item(3, 3, 3, 4, 1, 0, 1);
    add_item(0, 0, 999, 0, 1, 1, 0);               // distance equal to the cutoff
    add_item(0, 0, 998, 0, 1, 0, 1);
    add_item(0, 0, 0, 0, 0, 1, 0);                 // markers around one element
    add_item(100, 100, 101, 101, 1, 0, 0);
    add_item(0, 0, 0, 0, 0, 0, 1);
    add_item(0, 0, 500, 0, 1, 1, 0);               // left open across a cutoff write
    wait_drained();

    write_cutoff(dist_t'(0));
    add_item(0, 0, 400, 0, 1, 0, 1);
    add_item(5, 5, 5, 5, 1, 1, 1);                 // nothing is under a zero cutoff
    wait_drained();

    write_cutoff(dist_t'(4095));
    add_item(0, 0, COORD_MAX, COORD_MAX, 1, 1, 1);
    add_item(COORD_MAX, 0, 0, COORD_MAX, 1, 1, 1);
    wait_drained();

    // Random phases, each under its own cutoff.
    phase_start = items_queued;
    for (int phase = 0; items_queued < phase_start + RAND_ITEMS; phase++) begin
      case (phase % 5)
        0: write_cutoff(dist_t'($urandom_range(60)));
        1: write_cutoff(dist_t'($urandom_range(1600)));
        2: write_cutoff(dist_t'($urandom_range(4095)));
        3: write_cutoff(dist_t'(1));
        default: write_cutoff(dist_t'(999));
      endcase
      no_idle = (phase == 1);
      if (phase == 2) begin
        // Short searches while the receiver holds off, so the block backs up.
        rx_hold_req++;
        for (int k = 0; k < 60; k++) add_search($urandom_range(1, 2));
      end else begin
        for (int k = 0; k < 25; k++) add_search($urandom_range(1, 8));
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hnes_pkg.sv
rtl/hnes_if.sv
rtl/hnes_dist.sv
rtl/hex_nearest_element_search.sv
tb/tb_hex_nearest_element_search.sv
